// File: rtl/mecanum_wheel_odometry_top_defines.svh
// Assertion macros for the mecanum odometry block.
`ifndef MECANUM_WHEEL_ODOMETRY_TOP_DEFINES_SVH
`define MECANUM_WHEEL_ODOMETRY_TOP_DEFINES_SVH
// Clocked implication check with reset disable.
`define MWO_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check with reset disable.
`define MWO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/mwo_pkg.sv
// Shared types, constants and tables for the mecanum odometry block.
package mwo_pkg;

  localparam int unsigned COUNT_BITS_DEF     = 32;
  localparam int unsigned TRIG_FRAC_BITS_DEF = 16;
  localparam int unsigned ANGLE_FRAC         = 16;
  localparam logic [31:0] DIST_RESET         = 32'd8590;
  localparam logic [31:0] ANGLE_RESET        = 32'd41680000;
  localparam logic [31:0] GAIN_Q30           = 32'd652032874;
  localparam logic [63:0] SMAX               = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN               = 64'h8000_0000_0000_0000;

  // Configuration register indexes.
  localparam logic [0:0] REG_DIST  = 1'b0;
  localparam logic [0:0] REG_ANGLE = 1'b1;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_DELTA, ST_SUMS, ST_MUL_DX, ST_MUL_DY, ST_MUL_TH,
    ST_CORDIC, ST_ROT0, ST_ROT1, ST_ROT2, ST_ROT3, ST_ACC, ST_OUT
  } state_e;

  // Multiplier operand selects.
  typedef enum logic [2:0] {
    MS_SX_DIST, MS_SY_DIST, MS_ST_ANG, MS_DX_C, MS_DY_S, MS_DX_S, MS_DY_C
  } msel_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic  load;
    logic  delta;
    logic  sums;
    logic  mul_lo;
    logic  mul_en;
    msel_e msel;
    logic  cordic_start;
    logic  cordic_step;
    logic  acc;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic cordic_done;
  } stat_t;

  // Arctangent table, binary angle units.
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E; 5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4; 5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55; 5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001; default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Saturating 64-bit add.
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if ((a[63] == b[63]) && (r[63] != a[63])) r = a[63] ? SMIN : SMAX;
    return r;
  endfunction

  // Saturating 64-bit subtract.
  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if ((a[63] != b[63]) && (r[63] != a[63])) r = a[63] ? SMIN : SMAX;
    return r;
  endfunction

endpackage

// File: rtl/mwo_ctrl.sv
// Sequencing controller for the mecanum odometry block.
module mwo_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic          in_link_i,
  input  logic          out_fire_i,
  input  mwo_pkg::stat_t stat_i,
  output mwo_pkg::cmd_t  cmd_o,
  output logic          in_ready_o,
  output logic          out_valid_o
);
  import mwo_pkg::*;

  state_e state_q, state_d;
  logic   mph_q, mph_d;
  logic   mul_st;

  // State register and multiply phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mph_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mph_q   <= mph_d;
    end
  end

  // Each product has a low-half phase and then a high-half phase.
  always_comb begin
    unique case (state_q)
      ST_MUL_DX, ST_MUL_DY, ST_MUL_TH, ST_ROT0, ST_ROT1, ST_ROT2, ST_ROT3: mph_d = !mph_q;
      default: mph_d = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire_i && in_link_i) state_d = ST_DELTA;
      ST_DELTA:  state_d = ST_SUMS;
      ST_SUMS:   state_d = ST_MUL_DX;
      ST_MUL_DX: if (mph_q) state_d = ST_MUL_DY;
      ST_MUL_DY: if (mph_q) state_d = ST_MUL_TH;
      ST_MUL_TH: if (mph_q) state_d = ST_CORDIC;
      ST_CORDIC: if (stat_i.cordic_done) state_d = ST_ROT0;
      ST_ROT0:   if (mph_q) state_d = ST_ROT1;
      ST_ROT1:   if (mph_q) state_d = ST_ROT2;
      ST_ROT2:   if (mph_q) state_d = ST_ROT3;
      ST_ROT3:   if (mph_q) state_d = ST_ACC;
      ST_ACC:    state_d = ST_OUT;
      ST_OUT:    if (out_fire_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    cmd_o.msel = MS_SX_DIST;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    mul_st = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_fire_i && in_link_i;
      end
      ST_DELTA: cmd_o.delta = 1'b1;
      ST_SUMS: cmd_o.sums = 1'b1;
      ST_MUL_DX: begin
        mul_st = 1'b1; cmd_o.msel = MS_SX_DIST;
      end
      ST_MUL_DY: begin
        mul_st = 1'b1; cmd_o.msel = MS_SY_DIST;
      end
      ST_MUL_TH: begin
        mul_st = 1'b1; cmd_o.msel = MS_ST_ANG; cmd_o.cordic_start = 1'b1;
      end
      ST_CORDIC: cmd_o.cordic_step = 1'b1;
      ST_ROT0: begin
        mul_st = 1'b1; cmd_o.msel = MS_DX_C;
      end
      ST_ROT1: begin
        mul_st = 1'b1; cmd_o.msel = MS_DY_S;
      end
      ST_ROT2: begin
        mul_st = 1'b1; cmd_o.msel = MS_DX_S;
      end
      ST_ROT3: begin
        mul_st = 1'b1; cmd_o.msel = MS_DY_C;
      end
      ST_ACC: cmd_o.acc = 1'b1;
      ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
    cmd_o.mul_lo = mul_st && !mph_q;
    cmd_o.mul_en = mul_st && mph_q;
  end

endmodule

// File: rtl/mwo_datapath.sv
// Datapath for the mecanum odometry block: deltas, shared multiplier, CORDIC, accumulators.
module mwo_datapath #(
  parameter int unsigned COUNT_BITS     = mwo_pkg::COUNT_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = mwo_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mwo_pkg::cmd_t  cmd_i,
  output mwo_pkg::stat_t stat_o,
  input  logic [31:0]   enc_one_i,
  input  logic [31:0]   enc_two_i,
  input  logic [31:0]   enc_three_i,
  input  logic [31:0]   enc_four_i,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  output logic [63:0]   world_x_o,
  output logic [63:0]   world_y_o,
  output logic [31:0]   heading_o,
  output logic [63:0]   body_dx_o,
  output logic [63:0]   body_dy_o
);
  import mwo_pkg::*;

  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned F  = TRIG_FRAC_BITS;
  localparam int unsigned NIT = F + 1;
  localparam int unsigned IW  = $clog2(NIT + 1);
  // CORDIC register width: magnitude stays below 2^(F+1).
  localparam int unsigned CW  = F + 3;
  localparam logic [31:0] X0 = 32'((64'(GAIN_Q30) + (64'd1 << (29 - F))) >> (30 - F));

  logic [31:0] dist_q, angle_q;
  logic [CB-1:0] last_q [4];
  logic [CB-1:0] w_q [4];
  logic [CB-1:0] d_q [4];
  logic [CB+1:0] sx_q, sy_q, st_q;
  logic [63:0] bdx_q, bdy_q, px_q, py_q, p0_q, p1_q, p2_q, p3_q;
  logic [31:0] head_q, dth_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic [31:0] cz_q;
  logic        flip_q;
  logic [IW-1:0] it_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q  <= DIST_RESET;
      angle_q <= ANGLE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIST:  dist_q  <= cfg_data_i;
        REG_ANGLE: angle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Wheel remap, deltas and kinematic sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) last_q[i] <= '0;
    end else if (cmd_i.delta) begin
      for (int i = 0; i < 4; i++) last_q[i] <= w_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q[0] <= CB'(32'd0 - enc_two_i);
      w_q[1] <= CB'(32'd0 - enc_three_i);
      w_q[2] <= enc_four_i[CB-1:0];
      w_q[3] <= enc_one_i[CB-1:0];
    end
    if (cmd_i.delta) begin
      for (int i = 0; i < 4; i++) d_q[i] <= w_q[i] - last_q[i];
    end
    if (cmd_i.sums) begin
      sx_q <= $signed({{2{d_q[0][CB-1]}}, d_q[0]}) + $signed({{2{d_q[1][CB-1]}}, d_q[1]})
            + $signed({{2{d_q[2][CB-1]}}, d_q[2]}) + $signed({{2{d_q[3][CB-1]}}, d_q[3]});
      sy_q <= $signed({{2{d_q[1][CB-1]}}, d_q[1]}) + $signed({{2{d_q[3][CB-1]}}, d_q[3]})
            - $signed({{2{d_q[0][CB-1]}}, d_q[0]}) - $signed({{2{d_q[2][CB-1]}}, d_q[2]});
      st_q <= $signed({{2{d_q[2][CB-1]}}, d_q[2]}) + $signed({{2{d_q[3][CB-1]}}, d_q[3]})
            - $signed({{2{d_q[0][CB-1]}}, d_q[0]}) - $signed({{2{d_q[1][CB-1]}}, d_q[1]});
    end
  end

  // Shared multiplier: operand select and magnitudes, then a 32-by-32 product
  // per cycle, low half of the first operand first, high half second.
  logic [63:0] ma, mb;
  logic [5:0]  msh;
  logic        mneg;
  logic [63:0] am;
  logic [31:0] bm;
  logic [31:0] amh;
  logic [63:0] part;
  logic [63:0] plo_q;
  logic [95:0] prod, sprod;
  logic [95:0] shf;
  logic [63:0] mag, mres;

  always_comb begin
    ma = 64'(signed'(sx_q));
    mb = {32'd0, dist_q};
    msh = 6'd2;
    unique case (cmd_i.msel)
      MS_SX_DIST: begin ma = 64'(signed'(sx_q)); mb = {32'd0, dist_q}; end
      MS_SY_DIST: begin ma = 64'(signed'(sy_q)); mb = {32'd0, dist_q}; end
      MS_ST_ANG:  begin ma = 64'(signed'(st_q)); mb = {32'd0, angle_q}; end
      MS_DX_C:    begin ma = bdx_q; mb = 64'(cx_q); msh = 6'(F); end
      MS_DY_S:    begin ma = bdy_q; mb = 64'(cy_q); msh = 6'(F); end
      MS_DX_S:    begin ma = bdx_q; mb = 64'(cy_q); msh = 6'(F); end
      MS_DY_C:    begin ma = bdy_q; mb = 64'(cx_q); msh = 6'(F); end
      default: ;
    endcase
    if (cmd_i.msel == MS_DX_C || cmd_i.msel == MS_DY_C) begin
      mb = flip_q ? 64'(-cx_q) : 64'(cx_q);
    end else if (cmd_i.msel == MS_DY_S || cmd_i.msel == MS_DX_S) begin
      mb = flip_q ? 64'(-cy_q) : 64'(cy_q);
    end
    mneg  = ma[63] ^ mb[63];
    am    = ma[63] ? (64'd0 - ma) : ma;
    bm    = mb[63] ? 32'(64'd0 - mb) : mb[31:0];
    amh   = cmd_i.mul_lo ? am[31:0] : am[63:32];
    part  = {32'd0, amh} * {32'd0, bm};
    prod  = 96'(plo_q) + {part, 32'd0};
    sprod = mneg ? (96'd0 - prod) : prod;
    shf   = prod >> msh;
    mag   = ((shf[95:64] != '0) || shf[63]) ? SMAX : shf[63:0];
    mres  = mneg ? (64'd0 - mag) : mag;
  end

  // Low partial product, held for the high-half cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) plo_q <= part;
  end

  // Product registers; the heading step keeps the wrapped middle bits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      unique case (cmd_i.msel)
        MS_SX_DIST: bdx_q <= mres;
        MS_SY_DIST: bdy_q <= mres;
        MS_ST_ANG:  dth_q <= sprod[ANGLE_FRAC+31:ANGLE_FRAC];
        MS_DX_C:    p0_q  <= mres;
        MS_DY_S:    p1_q  <= mres;
        MS_DX_S:    p2_q  <= mres;
        MS_DY_C:    p3_q  <= mres;
        default: ;
      endcase
    end
  end

  // CORDIC rotation, one iteration per cycle.
  logic [31:0] cz_fold;
  logic [4:0]  it_idx;
  assign it_idx = 5'(it_q);
  assign cz_fold = head_q - 32'h8000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q <= '0;
    end else if (cmd_i.cordic_start) begin
      it_q <= '0;
    end else if (cmd_i.cordic_step && (it_q != IW'(NIT))) begin
      it_q <= it_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_start) begin
      flip_q <= head_q[31] ^ head_q[30];
      cz_q   <= (head_q[31] ^ head_q[30]) ? cz_fold : head_q;
      cx_q   <= CW'(X0);
      cy_q   <= '0;
    end else if (cmd_i.cordic_step && (it_q != IW'(NIT))) begin
      if (cz_q[31]) begin
        cx_q <= cx_q + (cy_q >>> it_q);
        cy_q <= cy_q - (cx_q >>> it_q);
        cz_q <= cz_q + atan_lut(it_idx);
      end else begin
        cx_q <= cx_q - (cy_q >>> it_q);
        cy_q <= cy_q + (cx_q >>> it_q);
        cz_q <= cz_q - atan_lut(it_idx);
      end
    end
  end

  assign stat_o.cordic_done = (it_q == IW'(NIT)) && cmd_i.cordic_step;

  // World accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
      head_q <= '0;
    end else if (cmd_i.acc) begin
      px_q <= sat_add(px_q, sat_sub(p0_q, p1_q));
      py_q <= sat_add(py_q, sat_add(p2_q, p3_q));
      head_q <= head_q + dth_q;
    end
  end

  assign world_x_o = px_q;
  assign world_y_o = py_q;
  assign heading_o = head_q;
  assign body_dx_o = bdx_q;
  assign body_dy_o = bdy_q;

endmodule

// File: rtl/mecanum_wheel_odometry_top.sv
// Top level of the mecanum four-wheel odometry block.
// Usage:
//   s_axis carries one beat per encoder report: tuser is link_ok, tdata holds
//   enc_one..enc_four. A beat with link_ok clear is taken and dropped.
//   m_axis returns one beat per valid report: world x, y, heading, body dx, dy.
//   Configuration writes (dist_per_count, angle_per_count) take effect at once;
//   the user sees that they are made only while the block is idle (not enforced).
// Sequence:
//   After a valid report is taken, the block forms deltas and sums, then seven
//   products on the shared 32-by-32 multiplier, each as a low half and a high
//   half, with the one-step-per-cycle CORDIC between the third and fourth, and
//   then accumulates before m_axis_tvalid rises. The next report is taken only
//   after the result beat has been taken. s_axis_tready is high only when idle.
// Reset:
//   Clears position, heading and stored counts; registers take their defaults.
// Stall:
//   The result beat holds on m_axis until tready, and no new report is taken.
module mecanum_wheel_odometry_top #(
  parameter int unsigned COUNT_BITS     = mwo_pkg::COUNT_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = mwo_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // enc_one, enc_two, enc_three, enc_four
  input  logic         s_axis_tuser,  // link_ok
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [287:0] m_axis_tdata,  // world_x, world_y, heading, body_dx, body_dy
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import mwo_pkg::*;
  `include "mecanum_wheel_odometry_top_defines.svh"

  cmd_t  cmd;
  stat_t stat;
  logic  in_fire, out_fire;
  logic [63:0] wx, wy, bdx, bdy;
  logic [31:0] hd;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  mwo_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(in_fire), .in_link_i(s_axis_tuser), .out_fire_i(out_fire),
    .stat_i(stat), .cmd_o(cmd),
    .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid)
  );

  mwo_datapath #(.COUNT_BITS(COUNT_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .enc_one_i(s_axis_tdata[31:0]), .enc_two_i(s_axis_tdata[63:32]),
    .enc_three_i(s_axis_tdata[95:64]), .enc_four_i(s_axis_tdata[127:96]),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .world_x_o(wx), .world_y_o(wy), .heading_o(hd), .body_dx_o(bdx), .body_dy_o(bdy)
  );

  assign m_axis_tdata = {bdy, bdx, hd, wy, wx};

  // Checks on the handshake relation between the two channels.
  `MWO_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready,
                   "input taken while a result is pending")
  `MWO_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `MWO_ASSERT_NEXT(a_drop, clk_i, rst_ni, in_fire && !s_axis_tuser, s_axis_tready,
                   "invalid report started work")

endmodule
